@@ rtl/att_pkg.sv @@
// Shared constants, register indexes and sequencer states for the averaged threshold trigger.
package att_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int TIME_W     = 24;
  localparam int CNT_W      = TIME_W + 1;
  localparam int LEN_W      = 5;
  localparam int IDX_W      = 3;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_AUTO_LEVEL   = 3'd1,
    REG_SUSTAIN_TIME = 3'd2,
    REG_HOLD_TIME    = 3'd3,
    REG_POLARITY     = 3'd4,
    REG_WINDOW_SIZE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_DECIDE
  } state_t;

endpackage

@@ rtl/averaged_threshold_trigger.sv @@
// Averaged threshold trigger: moving average, serial divider and trigger/hold sequencer.
//
// Usage. Each input word carries a signed Q16.16 sample and an unsigned Q8.16
// time step; it is taken when in_valid and in_ready are both high. Every input
// word yields exactly one output word (average, triggering, fired, released),
// offered on out_valid and taken when out_ready is high.
// Processing. After a word is accepted the block updates the window sum, loads
// the divider, runs the restoring divider (one quotient bit per cycle, for every
// bit of the sum width) and then makes the trigger decision. A new word is taken
// only once the block has finished the previous one and returned to idle.
// Stalls. The result sits in an output register, so in_ready returns while an
// earlier result still waits; a following result only waits in the decision
// step until the receiver has taken the previous one.
// Reset. rst is synchronous and active high: registers return to their
// defaults (window_size of one), the window reads as zero through per-entry
// valid bits, the trigger is idle and both countdowns are zero.
// Configuration is written through cfg_we, cfg_index and cfg_data, by the user
// only while the block is idle, which the block itself does not enforce; writing
// window_size also empties the window and reloads the sustain countdown.
module averaged_threshold_trigger (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [att_pkg::IDX_W-1:0]           cfg_index,
  input  logic [att_pkg::SAMPLE_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [att_pkg::SAMPLE_W-1:0] sample,
  input  logic [att_pkg::TIME_W-1:0]          time_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [att_pkg::SAMPLE_W-1:0] average,
  output logic                                triggering,
  output logic                                fired,
  output logic                                released
);
  import att_pkg::*;

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] threshold;
  logic signed [SAMPLE_W-1:0] auto_level;
  logic [TIME_W-1:0]          sustain_time;
  logic [TIME_W-1:0]          hold_time;
  logic                       polarity;
  logic [LEN_W-1:0]           window_size;

  // Window storage; an entry whose valid bit is clear reads as zero.
  logic signed [SAMPLE_W-1:0] win [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      win_vld;
  logic [SLOT_W-1:0]          write_slot;
  logic signed [SUM_W-1:0]    window_sum;

  // Trigger state.
  logic                       active;
  logic signed [CNT_W-1:0]    sustain_left;
  logic signed [CNT_W-1:0]    hold_left;

  // Latched input word.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]          dt_r;

  // Divider.
  logic [SUM_W-1:0]           quo;
  logic [LEN_W-1:0]           rem;
  logic                       sum_neg;
  logic [DIV_CNT_W-1:0]       div_cnt;

  state_t state, state_next;

  // Effective window length, clamped into one to WINDOW_MAX.
  logic [LEN_W-1:0] eff_len;
  always_comb begin
    if (window_size == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = window_size;
    end
  end

  // Window update.
  logic [SLOT_W-1:0]          slot_eff;
  logic [LEN_W-1:0]           slot_inc;
  logic [SLOT_W-1:0]          write_slot_next;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    sum_acc;

  always_comb begin
    slot_eff        = (LEN_W'(write_slot) >= eff_len) ? '0 : write_slot;
    slot_inc        = LEN_W'(slot_eff) + LEN_W'(1);
    write_slot_next = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];
    old_sample      = win_vld[slot_eff] ? win[slot_eff] : '0;
    sum_acc         = window_sum - SUM_W'(old_sample) + SUM_W'(sample_r);
  end

  // One restoring division step.
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W+1:0] rem_diff;
  logic             rem_ge;
  always_comb begin
    rem_sh   = {rem, quo[SUM_W-1]};
    rem_diff = {1'b0, rem_sh} - {2'b00, eff_len};
    rem_ge   = ~rem_diff[LEN_W+1];
  end

  // Countdown by the time step, floored at the most negative count.
  function automatic logic signed [CNT_W-1:0] count_down(
    input logic signed [CNT_W-1:0] c,
    input logic [TIME_W-1:0]       dt
  );
    logic [CNT_W:0] d;
    d = {c[CNT_W-1], c} - {2'b00, dt};
    if (d[CNT_W] && !d[CNT_W-1]) begin
      count_down = {1'b1, {(CNT_W-1){1'b0}}};
    end else begin
      count_down = d[CNT_W-1:0];
    end
  endfunction

  // Trigger decision on the finished quotient.
  logic signed [SAMPLE_W-1:0] avg_c;
  logic                       beyond_auto;
  logic                       beyond_thr;
  logic                       active_next;
  logic signed [CNT_W-1:0]    sustain_next;
  logic signed [CNT_W-1:0]    hold_next;
  logic                       fired_c;
  logic                       released_c;

  always_comb begin
    avg_c        = sum_neg ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
    beyond_auto  = polarity ? (avg_c < auto_level) : (avg_c > auto_level);
    beyond_thr   = polarity ? (avg_c < threshold) : (avg_c > threshold);
    active_next  = active;
    sustain_next = sustain_left;
    hold_next    = hold_left;
    fired_c      = 1'b0;
    released_c   = 1'b0;
    if (!active) begin
      if (beyond_auto) begin
        fired_c = 1'b1;
      end else if (beyond_thr) begin
        sustain_next = count_down(sustain_left, dt_r);
        fired_c      = sustain_next[CNT_W-1];
      end else begin
        sustain_next = {1'b0, sustain_time};
      end
      if (fired_c) begin
        active_next = 1'b1;
        hold_next   = {1'b0, hold_time};
      end
    end else begin
      if (beyond_thr) begin
        hold_next = {1'b0, hold_time};
      end else begin
        hold_next = count_down(hold_left, dt_r);
        if (hold_next[CNT_W-1]) begin
          released_c   = 1'b1;
          active_next  = 1'b0;
          sustain_next = {1'b0, sustain_time};
        end
      end
    end
  end

  // Sequencer: next state and handshake.
  logic commit;
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_ACCUM;
      end
      ST_ACCUM:  state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_cnt == DIV_CNT_W'(SUM_W - 1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state, configuration and trigger registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= '0;
      auto_level   <= '0;
      sustain_time <= '0;
      hold_time    <= '0;
      polarity     <= 1'b0;
      window_size  <= LEN_W'(1);
      win_vld      <= '0;
      write_slot   <= '0;
      window_sum   <= '0;
      active       <= 1'b0;
      sustain_left <= '0;
      hold_left    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD:    threshold    <= cfg_data;
          REG_AUTO_LEVEL:   auto_level   <= cfg_data;
          REG_SUSTAIN_TIME: sustain_time <= cfg_data[TIME_W-1:0];
          REG_HOLD_TIME:    hold_time    <= cfg_data[TIME_W-1:0];
          REG_POLARITY:     polarity     <= cfg_data[0];
          REG_WINDOW_SIZE: begin
            window_size  <= cfg_data[LEN_W-1:0];
            win_vld      <= '0;
            write_slot   <= '0;
            window_sum   <= '0;
            sustain_left <= {1'b0, sustain_time};
          end
          default: ;
        endcase
      end
      if (state == ST_ACCUM) begin
        win_vld[slot_eff] <= 1'b1;
        write_slot        <= write_slot_next;
        window_sum        <= sum_acc;
      end
      if (commit) begin
        active       <= active_next;
        sustain_left <= sustain_next;
        hold_left    <= hold_next;
        out_valid    <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and divider registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= sample;
      dt_r     <= time_step;
    end
    if (state == ST_ACCUM) begin
      win[slot_eff] <= sample_r;
    end
    if (state == ST_LOAD) begin
      quo     <= window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
      sum_neg <= window_sum[SUM_W-1];
      rem     <= '0;
      div_cnt <= '0;
    end
    if (state == ST_DIVIDE) begin
      quo     <= {quo[SUM_W-2:0], rem_ge};
      rem     <= rem_ge ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (commit) begin
      average    <= avg_c;
      triggering <= active_next;
      fired      <= fired_c;
      released   <= released_c;
    end
  end

  // The next write position always lies inside the effective window.
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(write_slot) < eff_len)
    else $error("write_slot outside the effective window");

  // An accepted word keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A word that fires the trigger leaves it active; one that releases leaves it idle.
  a_fired_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> triggering && !released)
    else $error("fired without an active trigger");

  a_released_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && released |-> !triggering)
    else $error("released with the trigger still active");

  // A result is only loaded when the previous one has gone or is being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    commit |-> !out_valid || out_ready)
    else $error("output word overwritten before it was taken");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the averaged threshold trigger: directed table, then random phases.
module testbench;
  import att_pkg::*;

  // Generous ceiling on the run.
  localparam int CYCLE_LIMIT = 300000;
  localparam int WORDS_PER_PHASE = 50;
  localparam int PHASES = 10;
  // The receiver's deliberate long hold-off, long enough to fill the block several times.
  localparam int LONG_HOLD_CYCLES = 400;
  localparam longint COUNT_FLOOR = -64'sd16777216;
  // An index that selects no register; writes to it must leave everything alone.
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] average;
    logic               triggering;
    logic               fired;
    logic               released;
  } trig_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // One row of the directed table: either a register write or an input word. Word rows may carry
  // an expected result typed in by hand; the others are checked against the predictor.
  typedef struct packed {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        value;
    logic [23:0]        dt;
    logic               typed;
    trig_result_t       want;
  } dir_row_t;

  localparam int DIR_ROWS = 33;
  localparam trig_result_t NO_RESULT = '0;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Reset defaults: window of one, both levels at zero, zero times, greater-than compares.
    '{ROW_WORD, '0, 32'h0000_0000, 24'h000000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{ROW_WORD, '0, 32'h7FFF_FFFF, 24'h000000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, '0, 32'h8000_0000, 24'h000000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0, 1'b0}},
    '{ROW_WORD, '0, 32'hFFFF_FFFF, 24'h000001, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}},
    '{ROW_WORD, '0, 32'h0000_0001, 24'hFFFFFF, 1'b1, '{32'h0000_0001, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, '0, 32'h0000_0000, 24'hFFFFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1}},
    // Less-than compares: a negative average fires straight through the auto level.
    '{ROW_CFG, REG_POLARITY, 32'h0000_0001, 24'h0, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'hFFFF_FFFB, 24'h000000, 1'b1, '{32'hFFFF_FFFB, 1'b1, 1'b1, 1'b0}},
    '{ROW_WORD, '0, 32'h0000_0003, 24'h000002, 1'b1, '{32'h0000_0003, 1'b0, 1'b0, 1'b1}},
    // Upper data bits must be ignored for the narrow registers.
    '{ROW_CFG, REG_POLARITY, 32'hFFFF_FFFE, 24'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_AUTO_LEVEL, 32'h7FFF_FFFF, 24'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_THRESHOLD, 32'h0000_0064, 24'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_SUSTAIN_TIME, 32'hFF00_000A, 24'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_HOLD_TIME, 32'h0000_0006, 24'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_WINDOW_SIZE, 32'h0000_0004, 24'h0, 1'b0, NO_RESULT},
    // Sustained firing over a window of four, then a negative sum truncated toward zero
    // and the hold countdown running out.
    '{ROW_WORD, '0, 32'h0000_03E8, 24'h000004, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h0000_03E8, 24'h000004, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'hFFFF_FFF9, 24'h000004, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'hFFFF_F830, 24'h000004, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h0000_0000, 24'h000004, 1'b0, NO_RESULT},
    // Window lengths out of range: zero acts as one, anything above the maximum as the maximum.
    '{ROW_CFG, REG_WINDOW_SIZE, 32'h0000_0000, 24'h0, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h8000_0000, 24'hFFFFFF, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_WINDOW_SIZE, 32'h0000_0011, 24'h0, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h7FFF_FFFF, 24'h000000, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h7FFF_FFFF, 24'h000000, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_WINDOW_SIZE, 32'h0000_001F, 24'h0, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h8000_0000, 24'h000000, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h8000_0000, 24'h000000, 1'b0, NO_RESULT},
    // A write to an index with no register behind it changes nothing.
    '{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, 24'h0, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h0000_0005, 24'h000000, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_THRESHOLD, 32'h8000_0000, 24'h0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_WINDOW_SIZE, 32'hFFFF_FFE1, 24'h0, 1'b0, NO_RESULT},
    '{ROW_WORD, '0, 32'h1234_5678, 24'hABCDEF, 1'b0, NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   sample = '0;
  logic [TIME_W-1:0]    time_step = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   average;
  logic                 triggering;
  logic                 fired;
  logic                 released;

  averaged_threshold_trigger i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .time_step  (time_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .average    (average),
    .triggering (triggering),
    .fired      (fired),
    .released   (released)
  );

  always #4 clk = ~clk;

  // Predictor copy of the configuration registers, at their reset values.
  logic signed [31:0] lvl_threshold = '0;
  logic signed [31:0] lvl_auto = '0;
  logic [23:0]        t_sustain = '0;
  logic [23:0]        t_hold = '0;
  logic               cmp_below = 1'b0;
  logic [4:0]         win_len_reg = 5'd1;

  // Predictor copy of the block's state.
  logic signed [31:0] win_samples [WINDOW_MAX];
  int unsigned        win_slot = 0;
  longint             win_sum = 0;
  bit                 trig_active = 1'b0;
  longint             sustain_cnt = 0;
  longint             hold_cnt = 0;

  // Results worked out for accepted words, oldest first, waiting for the block to produce them.
  trig_result_t awaited_results[$];
  int           mismatches = 0;
  int           cycle_count = 0;

  // Knobs shared between the stimulus and the receiver.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold = 1'b0;
  int rx_stall_left = 0;

  // Shape of the random words in the current phase.
  int lvl_center = 0;
  int lvl_spread = 16;
  int step_span = 100;

  initial foreach (win_samples[k]) win_samples[k] = '0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic bit passes(logic signed [31:0] x, logic signed [31:0] lvl);
    return cmp_below ? (x < lvl) : (x > lvl);
  endfunction

  // Countdowns never go below the floor of minus two to the twenty-fourth.
  function automatic longint tick_down(longint c, logic [23:0] dt);
    longint r;
    r = c - longint'(dt);
    return (r < COUNT_FLOOR) ? COUNT_FLOOR : r;
  endfunction

  function automatic void apply_register(logic [IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      REG_THRESHOLD:    lvl_threshold = data;
      REG_AUTO_LEVEL:   lvl_auto = data;
      REG_SUSTAIN_TIME: t_sustain = data[23:0];
      REG_HOLD_TIME:    t_hold = data[23:0];
      REG_POLARITY:     cmp_below = data[0];
      REG_WINDOW_SIZE: begin
        // A new length empties the window and restarts the sustain countdown; the trigger
        // and the hold countdown carry on.
        win_len_reg = data[4:0];
        foreach (win_samples[k]) win_samples[k] = '0;
        win_slot = 0;
        win_sum = 0;
        sustain_cnt = t_sustain;
      end
      default: ;
    endcase
  endfunction

  // Moves the predicted state on by one word and returns the result that word should give.
  function automatic trig_result_t advance_trigger(logic signed [31:0] s, logic [23:0] dt);
    trig_result_t r;
    int unsigned  n;
    int unsigned  slot;
    longint       avg;
    n = (win_len_reg == 0) ? 1 : (win_len_reg > WINDOW_MAX) ? WINDOW_MAX : win_len_reg;
    slot = (win_slot >= n) ? 0 : win_slot;
    win_sum = win_sum - longint'(win_samples[slot]) + longint'(s);
    win_samples[slot] = s;
    slot++;
    win_slot = (slot >= n) ? 0 : slot;
    avg = win_sum / longint'(n);
    r = '0;
    r.average = avg[31:0];
    if (!trig_active) begin
      // Firing through the auto level leaves the sustain countdown where it was.
      if (passes(r.average, lvl_auto)) begin
        r.fired = 1'b1;
      end else if (passes(r.average, lvl_threshold)) begin
        sustain_cnt = tick_down(sustain_cnt, dt);
        if (sustain_cnt < 0) r.fired = 1'b1;
      end else begin
        sustain_cnt = t_sustain;
      end
      if (r.fired) begin
        trig_active = 1'b1;
        hold_cnt = t_hold;
      end
    end else begin
      if (passes(r.average, lvl_threshold)) begin
        hold_cnt = t_hold;
      end else begin
        hold_cnt = tick_down(hold_cnt, dt);
        if (hold_cnt < 0) begin
          r.released = 1'b1;
          trig_active = 1'b0;
          sustain_cnt = t_sustain;
        end
      end
    end
    r.triggering = trig_active;
    return r;
  endfunction

  // Register writes happen at a falling edge and take effect at the next rising edge.
  task automatic write_register(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    apply_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one input word, possibly after a random gap, and records its expected result
  // at the edge where it is taken. Called and returning at a falling edge.
  task automatic send_word(logic signed [31:0] s, logic [23:0] dt, bit typed,
                           trig_result_t want);
    trig_result_t predicted;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    time_step = dt;
    do @(posedge clk); while (!in_ready);
    predicted = advance_trigger(s, dt);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Lets every outstanding result come back; the block is then idle.
  task automatic wait_drained();
    while (awaited_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 4000));
    endcase
  endfunction

  // Samples mostly land near the levels of the phase so that the compares flip often.
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom;
      3:       return 32'sh0;
      default: return lvl_center + int'($urandom_range(0, 6 * lvl_spread)) - 3 * lvl_spread;
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(0, 19))
      0:       return 24'hFFFFFF;
      1:       return 24'h000000;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(0, step_span));
    endcase
  endfunction

  // The first two phases pin the levels and times at their extremes; the rest are random.
  task automatic configure_phase(int phase);
    logic signed [31:0] thr;
    logic signed [31:0] aut;
    logic [23:0]        sus;
    logic [23:0]        hld;
    logic               pol;
    logic [4:0]         wsz;
    bit                 keep_window;
    keep_window = 1'b0;
    case (phase)
      0: begin
        pol = 1'b0; thr = 32'sh8000_0000; aut = 32'sh7FFF_FFFF;
        sus = 24'hFFFFFF; hld = 24'hFFFFFF; wsz = 5'd16;
        lvl_center = 0; lvl_spread = 1 << 20; step_span = 24'hFFFFFF;
      end
      1: begin
        pol = 1'b1; thr = 32'sh7FFF_FFFF; aut = 32'sh8000_0000;
        sus = 24'h000000; hld = 24'h000000; wsz = 5'd31;
        lvl_center = 0; lvl_spread = 1 << 20; step_span = 3;
      end
      default: begin
        pol = 1'($urandom_range(0, 1));
        lvl_center = $signed($urandom) >>> $urandom_range(8, 31);
        lvl_spread = 1 << $urandom_range(2, 20);
        thr = lvl_center;
        if ($urandom_range(0, 3) == 0) aut = $urandom;
        else aut = pol ? lvl_center - 2 * lvl_spread : lvl_center + 2 * lvl_spread;
        sus = pick_time();
        hld = pick_time();
        wsz = 5'($urandom_range(0, 31));
        step_span = $urandom_range(1, 1500);
        keep_window = ($urandom_range(0, 2) == 0);
      end
    endcase
    // Junk in the unused upper data bits must not reach the narrow registers.
    write_register(REG_THRESHOLD, thr);
    write_register(REG_AUTO_LEVEL, aut);
    write_register(REG_SUSTAIN_TIME, ($urandom & 32'hFF00_0000) | 32'(sus));
    write_register(REG_HOLD_TIME, ($urandom & 32'hFF00_0000) | 32'(hld));
    write_register(REG_POLARITY, ($urandom & 32'hFFFF_FFFE) | 32'(pol));
    // Leaving the window alone now and then checks that the countdowns survive level writes.
    if (!keep_window) write_register(REG_WINDOW_SIZE, ($urandom & 32'hFFFF_FFE0) | 32'(wsz));
  endtask

  // Receiver: takes words, with random stalls and one long hold-off on request, during
  // which the block fills and stops taking input words.
  always @(negedge clk) begin
    if (rx_stall_left == 0) begin
      if (long_hold) begin
        rx_stall_left = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 15) == 0) begin
        rx_stall_left = $urandom_range(1, 17);
      end
    end
    if (rx_stall_left > 0) begin
      out_ready = 1'b0;
      rx_stall_left--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Every word taken from the block is compared, field by field, with the oldest expectation.
  always @(posedge clk) begin : watch_output
    trig_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("output word with nothing awaited, average", average, 0);
      end else begin
        want = awaited_results.pop_front();
        if (average !== want.average) report_mismatch("average", average, want.average);
        if (triggering !== want.triggering)
          report_mismatch("triggering", triggering, want.triggering);
        if (fired !== want.fired) report_mismatch("fired", fired, want.fired);
        if (released !== want.released) report_mismatch("released", released, want.released);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles with %0d results outstanding", cycle_count,
             awaited_results.size());
    $display("averaged_threshold_trigger test failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Register rows wait until the block has handed back every result.
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_CFG) begin
        wait_drained();
        write_register(DIRECTED[row].idx, DIRECTED[row].value);
      end else begin
        send_word(DIRECTED[row].value, DIRECTED[row].dt, DIRECTED[row].typed,
                  DIRECTED[row].want);
      end
    end

    // Random phases. Each starts with the sender paused until every result is back, then a
    // fresh setting. Idling stops for the closing phases so the block also runs flat out.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      tx_idle_on = (phase < PHASES - 2);
      rx_idle_on = (phase < PHASES - 2);
      configure_phase(phase);
      if (phase == 3) long_hold = 1'b1;
      repeat (WORDS_PER_PHASE) send_word(pick_sample(), pick_step(), 1'b0, NO_RESULT);
    end

    // Let the last results arrive, then watch a little longer for any stray word.
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("averaged_threshold_trigger test passed");
    end else begin
      $display("averaged_threshold_trigger test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/att_pkg.sv
rtl/averaged_threshold_trigger.sv
test/testbench.sv
